/* hdl/dgid_pkg.sv */
// Shared constants and token flag type for the dictionary group-id assigner.
`timescale 1ns / 1ps

package dgid_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 256;
    localparam int VALUE_BITS_DEFAULT  = 32;

    localparam int IN_VALUE_W = 32;   // cell_value field width
    localparam int ROW_W      = 32;   // row_number field width
    localparam int GID_W      = 8;    // group_id field width

    // Control part of the lookup token that walks the cell chain.
    typedef struct packed {
        logic valid;   // token present
        logic hit;     // matched a stored value
        logic ins;     // value was new and got written into a free cell
    } tok_flags_t;

endpackage

/* hdl/dgid_cell.sv */
// One dictionary cell: holds a stored value, checks and forwards the lookup token.
`timescale 1ns / 1ps

module dgid_cell #(
    parameter int TABLE_DEPTH = dgid_pkg::TABLE_DEPTH_DEFAULT,
    parameter int VALUE_BITS  = dgid_pkg::VALUE_BITS_DEFAULT,
    parameter int CELL_INDEX  = 0
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 adv,
    input  logic [$clog2(TABLE_DEPTH + 1) - 1:0] count,
    input  dgid_pkg::tok_flags_t                 in_flags,
    input  logic [VALUE_BITS - 1:0]              in_value,
    input  logic [$clog2(TABLE_DEPTH) - 1:0]     in_id,
    output dgid_pkg::tok_flags_t                 out_flags,
    output logic [VALUE_BITS - 1:0]              out_value,
    output logic [$clog2(TABLE_DEPTH) - 1:0]     out_id
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W  = $clog2(TABLE_DEPTH);

    logic [VALUE_BITS - 1:0] stored_reg;
    dgid_pkg::tok_flags_t    flags_reg;
    dgid_pkg::tok_flags_t    flags_next;
    logic [VALUE_BITS - 1:0] value_reg;
    logic [ID_W - 1:0]       id_reg;
    logic [ID_W - 1:0]       id_next;
    logic                    below;
    logic                    at_fill;
    logic                    pending;
    logic                    take_hit;
    logic                    take_ins;

    // cells below the fill count hold live entries; the cell at the fill count is the next free one
    assign below    = CNT_W'(CELL_INDEX) < count;
    assign at_fill  = CNT_W'(CELL_INDEX) == count;
    assign pending  = in_flags.valid && !in_flags.hit && !in_flags.ins;
    assign take_hit = pending && below && (stored_reg == in_value);
    assign take_ins = pending && at_fill;

    always_comb begin
        flags_next     = in_flags;
        flags_next.hit = in_flags.hit | take_hit;
        flags_next.ins = in_flags.ins | take_ins;
        id_next        = (take_hit || take_ins) ? ID_W'(CELL_INDEX) : in_id;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else if (adv) begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            value_reg <= in_value;
            id_reg    <= id_next;
        end
        if (adv && take_ins) begin
            stored_reg <= in_value;
        end
    end

    assign out_flags = flags_reg;
    assign out_value = value_reg;
    assign out_id    = id_reg;

endmodule

/* hdl/dictionary_group_id_assigner.sv */
// Top level of the dictionary group-id assigner: handshake, row count and cell chain.
`timescale 1ns / 1ps

//  channel | dir | tdata (low bit up)                 | tuser (low bit up)
//  s_      | in  | cell_value[31:0]                   | start_of_table
//  m_      | out | row_number[31:0], group_id[39:32]  | first_of_group, table_overflow
//
//  From acceptance, the lookup token steps through the entry register and then one cell
//  per cycle over the whole chain, unless a stalled output holds it, until m_tvalid rises.
//  A new row can be accepted the cycle after its predecessor leaves the chain, even while
//  that result still waits in the output register.
//  aresetn (synchronous) clears the fill count, row counter, token and output valids;
//  stored cell values are not cleared and only count once below the fill count.
//  A stalled output holds the token in the last cell until the word is taken.

module dictionary_group_id_assigner #(
    parameter int TABLE_DEPTH = dgid_pkg::TABLE_DEPTH_DEFAULT,
    parameter int VALUE_BITS  = dgid_pkg::VALUE_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // cell_value[31:0]
    input  logic [0:0]  s_tuser,   // start_of_table
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // row_number[31:0], group_id[39:32]
    output logic [1:0]  m_tuser    // first_of_group, table_overflow
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W  = $clog2(TABLE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } state_t;

    state_t                         state_reg, state_next;
    logic [CNT_W - 1:0]             count_reg, count_next;
    logic [dgid_pkg::ROW_W - 1:0]   row_counter_reg, row_counter_next;
    logic [dgid_pkg::ROW_W - 1:0]   row_item_reg, row_item_next;
    logic                           m_valid_reg, m_valid_next;
    logic [dgid_pkg::ROW_W - 1:0]   m_row_reg;
    logic [dgid_pkg::GID_W - 1:0]   m_gid_reg;
    logic                           m_first_reg;
    logic                           m_ovf_reg;
    dgid_pkg::tok_flags_t           entry_flags_reg, entry_flags_next;
    logic [VALUE_BITS - 1:0]        entry_value_reg;

    // token lanes: index 0 is the entry register, index k the output of cell k-1
    dgid_pkg::tok_flags_t           chain_flags [TABLE_DEPTH + 1];
    logic [VALUE_BITS - 1:0]        chain_value [TABLE_DEPTH + 1];
    logic [ID_W - 1:0]              chain_id    [TABLE_DEPTH + 1];

    logic                           accept;
    logic                           adv;
    logic                           exit_tok;
    dgid_pkg::tok_flags_t           last_flags;
    logic [dgid_pkg::ROW_W - 1:0]   row_base;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign last_flags = chain_flags[TABLE_DEPTH];
    // chain freezes only when a finished token finds the output word still occupied
    assign adv        = !(last_flags.valid && m_valid_reg && !m_tready);
    assign exit_tok   = last_flags.valid && adv;

    assign chain_flags[0] = entry_flags_reg;
    assign chain_value[0] = entry_value_reg;
    assign chain_id[0]    = '0;

    for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
        dgid_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .VALUE_BITS  (VALUE_BITS),
            .CELL_INDEX  (gi)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .count     (count_reg),
            .in_flags  (chain_flags[gi]),
            .in_value  (chain_value[gi]),
            .in_id     (chain_id[gi]),
            .out_flags (chain_flags[gi + 1]),
            .out_value (chain_value[gi + 1]),
            .out_id    (chain_id[gi + 1])
        );
    end

    assign row_base = s_tuser[0] ? '0 : row_counter_reg;

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        row_counter_next = row_counter_reg;
        row_item_next    = row_item_reg;
        entry_flags_next = entry_flags_reg;
        m_valid_next     = m_valid_reg;

        if (adv) begin
            entry_flags_next = '0;
        end
        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    // start flag empties the table and restarts numbering before this row
                    if (s_tuser[0]) begin
                        count_next = '0;
                    end
                    row_item_next          = row_base;
                    row_counter_next       = row_base + 1'b1;
                    entry_flags_next       = '0;
                    entry_flags_next.valid = 1'b1;
                    state_next             = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (exit_tok) begin
                    m_valid_next = 1'b1;
                    if (last_flags.ins) begin
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            row_counter_reg <= '0;
            entry_flags_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            row_counter_reg <= row_counter_next;
            entry_flags_reg <= entry_flags_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_item_reg <= row_item_next;
        if (accept) begin
            entry_value_reg <= VALUE_BITS'(s_tdata);
        end
        if (exit_tok) begin
            m_row_reg   <= row_item_reg;
            // a miss on a full table reports group 0 with the overflow flag
            m_gid_reg   <= (last_flags.hit || last_flags.ins)
                           ? dgid_pkg::GID_W'(chain_id[TABLE_DEPTH]) : '0;
            m_first_reg <= !last_flags.hit;
            m_ovf_reg   <= !last_flags.hit && !last_flags.ins;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_gid_reg, m_row_reg};
    assign m_tuser  = {m_ovf_reg, m_first_reg};

endmodule

/* hdl/dgid_checker.sv */
// Port-level checks for the dictionary group-id assigner, bound to the top level.
`timescale 1ns / 1ps

module dgid_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // a stalled result word holds still
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // one row at a time: input closes right after a row is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second row accepted while lookup in progress");

    // overflow only on a new value
    a_ovf_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("overflow without first_of_group");

    // overflow reports group zero
    a_ovf_gid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata[39:32] == 8'd0)
        else $error("overflow with nonzero group id");

endmodule

bind dictionary_group_id_assigner dgid_checker u_dgid_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* tb/tb_dictionary_group_id_assigner.sv */
// Self-checking testbench for the dictionary group-id assigner.
`timescale 1ns / 1ps

module tb_dictionary_group_id_assigner;

    localparam int DEPTH       = dgid_pkg::TABLE_DEPTH_DEFAULT;
    localparam int VBITS       = dgid_pkg::VALUE_BITS_DEFAULT;   // full 32-bit compare
    localparam int ROW_TARGET  = 1950;
    localparam int SETTLE_CYC  = DEPTH + 40;           // one row's trip through the chain plus margin

    // One result word, split into its fields.
    typedef struct packed {
        logic [dgid_pkg::ROW_W-1:0] row;
        logic [dgid_pkg::GID_W-1:0] gid;
        logic                       first;
        logic                       ovf;
    } group_result_t;

    // Directed row: stimulus plus an optional hand-written expectation.
    typedef struct packed {
        logic                            start;
        logic [dgid_pkg::IN_VALUE_W-1:0] value;
        logic                            typed;
        group_result_t                   want;
    } row_case_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata  = '0;   // cell_value[31:0]
    logic [0:0]         s_tuser  = '0;   // start_of_table
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [39:0]        m_tdata;         // row_number[31:0], group_id[39:32]
    logic [1:0]         m_tuser;         // first_of_group, table_overflow

    // Predictor state: stored distinct values, fill count and row count.
    logic [dgid_pkg::IN_VALUE_W-1:0] dict_values [DEPTH];
    int unsigned                     dict_fill  = 0;
    logic [dgid_pkg::ROW_W-1:0]      table_rows = '0;

    group_result_t pending_results [$];

    int unsigned mismatch_count = 0;
    int unsigned rows_sent      = 0;
    int unsigned words_checked  = 0;
    int unsigned tables_started = 0;
    int unsigned new_groups     = 0;
    int unsigned overflow_rows  = 0;
    int unsigned burst_left     = 0;
    int unsigned fills_done     = 0;
    logic [15:0] pattern_cycle  = '0;

    row_case_t directed_rows [20];

    dictionary_group_id_assigner #(
        .TABLE_DEPTH (DEPTH),
        .VALUE_BITS  (VBITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 aclk = ~aclk;

    // Dense id lookup: clear on start, search only the filled part, append or overflow.
    function automatic group_result_t assign_group(
            input logic start,
            input logic [dgid_pkg::IN_VALUE_W-1:0] value);
        group_result_t res;
        int unsigned   idx;
        logic          found;
        found = 1'b0;
        idx   = 0;
        if (start) begin
            dict_fill  = 0;
            table_rows = '0;
        end
        res.row    = table_rows;
        table_rows = table_rows + 1'b1;   // wraps at 2^32
        for (int unsigned i = 0; i < dict_fill; i++) begin
            if (!found && dict_values[i] == value) begin
                found = 1'b1;
                idx   = i;
            end
        end
        res.first = !found;
        res.ovf   = 1'b0;
        if (!found) begin
            if (dict_fill < DEPTH) begin
                idx              = dict_fill;
                dict_values[idx] = value;
                dict_fill        = dict_fill + 1;
            end else begin
                idx     = 0;
                res.ovf = 1'b1;
            end
        end
        res.gid = idx[dgid_pkg::GID_W-1:0];
        return res;
    endfunction

    // Offer one row, wait for the handshake, log what must come back, then pace the burst.
    task automatic send_row(input logic start,
                            input logic [dgid_pkg::IN_VALUE_W-1:0] value,
                            input logic typed, input group_result_t want);
        group_result_t predicted;
        int unsigned   gap;
        s_tvalid   <= 1'b1;
        s_tdata    <= value;
        s_tuser[0] <= start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = assign_group(start, value);
        pending_results = {pending_results, (typed ? want : predicted)};
        rows_sent++;
        if (start) tables_started++;
        if (predicted.first && !predicted.ovf) new_groups++;
        if (predicted.ovf) overflow_rows++;
        if (burst_left == 0) begin
            // long gaps now and then so the next row lands on every phase of the chain
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_plain(input logic start,
                              input logic [dgid_pkg::IN_VALUE_W-1:0] value);
        send_row(start, value, 1'b0, '0);
    endtask

    // Hold the input idle until every outstanding word has been returned.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // Fill the dictionary to the brim, then push new values past it and mix in repeats.
    task automatic fill_dictionary();
        logic [dgid_pkg::IN_VALUE_W-1:0] salt;
        int unsigned                     pick;
        salt = $urandom;
        send_plain(1'b1, salt);
        for (int unsigned i = 1; i < DEPTH; i++) send_plain(1'b0, salt + i);
        for (int unsigned k = 0; k < 24; k++) begin
            pick = $urandom_range(0, 2);
            if (pick == 0)      send_plain(1'b0, salt + DEPTH + k);           // new, no room
            else if (pick == 1) send_plain(1'b0, salt + DEPTH);               // overflows again
            else                send_plain(1'b0, salt + $urandom_range(0, DEPTH - 1));
        end
    endtask

    // Short table: values drawn from a small pool so repeats are common.
    task automatic random_table();
        logic [dgid_pkg::IN_VALUE_W-1:0] pool [12];
        int unsigned                     pool_size;
        int unsigned                     len;
        logic                            start;
        logic [dgid_pkg::IN_VALUE_W-1:0] value;
        pool_size = $urandom_range(1, 12);
        len       = $urandom_range(1, 40);
        for (int unsigned i = 0; i < 12; i++) begin
            case ($urandom_range(0, 9))
                0:       pool[i] = '0;
                1:       pool[i] = '1;
                default: pool[i] = $urandom;
            endcase
        end
        for (int unsigned r = 0; r < len; r++) begin
            // mostly a clean start on row 0; sometimes the table runs on, or restarts midway
            if (r == 0) start = ($urandom_range(0, 9) != 0);
            else        start = ($urandom_range(0, 49) == 0);
            value = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, pool_size - 1)];
            send_plain(start, value);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Receiver readiness: cycles through free-running, random, sparse and square-wave stalls.
    always @(posedge aclk) begin
        pattern_cycle <= pattern_cycle + 1'b1;
        case (pattern_cycle[10:9])
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
            2'd2:    m_tready <= (pattern_cycle % 3 == 0);
            default: m_tready <= pattern_cycle[2];
        endcase
    end

    // Compare every accepted result word with the oldest outstanding prediction.
    always @(posedge aclk) begin
        group_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            words_checked++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result word, expected none, got %0h/%0h",
                         $time, m_tdata, m_tuser);
            end else begin
                want = pending_results.pop_front();
                check_field("row_number", want.row, m_tdata[31:0]);
                check_field("group_id", 32'(want.gid), 32'(m_tdata[39:32]));
                check_field("first_of_group", 32'(want.first), 32'(m_tuser[0]));
                check_field("table_overflow", 32'(want.ovf), 32'(m_tuser[1]));
            end
        end
    end

    initial begin
        // start, value, typed, {row, group_id, first_of_group, table_overflow}
        directed_rows = '{
            '{1'b0, 32'h0000_0000, 1'b1, '{32'd0, 8'd0, 1'b1, 1'b0}},  // first row after reset
            '{1'b0, 32'hFFFF_FFFF, 1'b1, '{32'd1, 8'd1, 1'b1, 1'b0}},
            '{1'b0, 32'h0000_0000, 1'b1, '{32'd2, 8'd0, 1'b0, 1'b0}},  // repeat
            '{1'b0, 32'hFFFF_FFFF, 1'b1, '{32'd3, 8'd1, 1'b0, 1'b0}},
            '{1'b1, 32'hFFFF_FFFF, 1'b1, '{32'd0, 8'd0, 1'b1, 1'b0}},  // start clears table
            '{1'b0, 32'h0000_0000, 1'b1, '{32'd1, 8'd1, 1'b1, 1'b0}},
            '{1'b0, 32'h8000_0000, 1'b1, '{32'd2, 8'd2, 1'b1, 1'b0}},
            '{1'b0, 32'h0000_0001, 1'b1, '{32'd3, 8'd3, 1'b1, 1'b0}},
            '{1'b0, 32'h7FFF_FFFF, 1'b1, '{32'd4, 8'd4, 1'b1, 1'b0}},
            '{1'b0, 32'h8000_0000, 1'b1, '{32'd5, 8'd2, 1'b0, 1'b0}},
            '{1'b1, 32'h8000_0000, 1'b1, '{32'd0, 8'd0, 1'b1, 1'b0}},  // start on a known value
            '{1'b1, 32'h8000_0000, 1'b1, '{32'd0, 8'd0, 1'b1, 1'b0}},  // back-to-back starts
            '{1'b0, 32'h8000_0001, 1'b1, '{32'd1, 8'd1, 1'b1, 1'b0}},  // differs in bit 0
            '{1'b0, 32'h0000_0000, 1'b1, '{32'd2, 8'd2, 1'b1, 1'b0}},  // value from the earlier table must not hit
            '{1'b0, 32'h7FFF_FFFF, 1'b1, '{32'd3, 8'd3, 1'b1, 1'b0}},
            '{1'b0, 32'h0000_0001, 1'b1, '{32'd4, 8'd4, 1'b1, 1'b0}},
            '{1'b0, 32'hA5A5_A5A5, 1'b0, '0},
            '{1'b0, 32'h5A5A_5A5A, 1'b0, '0},
            '{1'b0, 32'h8000_0001, 1'b0, '0},
            '{1'b0, 32'hA5A5_A5A5, 1'b0, '0}
        };

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_row(directed_rows[i].start, directed_rows[i].value,
                     directed_rows[i].typed, directed_rows[i].want);

        drain_results();

        while (rows_sent < ROW_TARGET) begin
            if (fills_done < 2 && rows_sent >= 500 * (fills_done + 1)) begin
                fill_dictionary();
                fills_done++;
            end else begin
                random_table();
            end
            if ($urandom_range(0, 7) == 0) drain_results();
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);

        if (pending_results.size() != 0) begin
            mismatch_count += pending_results.size();
            $display("%0t: %0d result words never arrived", $time, pending_results.size());
        end

        $display("Run: %0d rows over %0d table starts, %0d words checked.",
                 rows_sent, tables_started, words_checked);
        $display("     %0d new groups assigned, %0d rows hit a full dictionary.",
                 new_groups, overflow_rows);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run with every gap and stall.
    initial begin
        #60_000_000;
        $display("Timeout with %0d result words outstanding", pending_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
hdl/dgid_pkg.sv
hdl/dgid_cell.sv
hdl/dictionary_group_id_assigner.sv
hdl/dgid_checker.sv
tb/tb_dictionary_group_id_assigner.sv
